[hw/rtl/coherence_txn_entry_fsm_core_defines.svh]
// Assertion macros for the coherence transaction entry FSM.
`ifndef COHERENCE_TXN_ENTRY_FSM_CORE_DEFINES_SVH
`define COHERENCE_TXN_ENTRY_FSM_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while in reset.
`define COH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("coherence entry fsm: implication check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define COH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("coherence entry fsm: next-cycle check failed");

`else

`define COH_ASSERT_IMP(lbl, ante, cons)
`define COH_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/coh_txn_pkg.sv]
// Shared types, codes and helpers for the coherence transaction entry FSM.
package coh_txn_pkg;

    // Entry states
    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_LOOKUP     = 4'd1,
        ST_WAITSNOOP  = 4'd2,
        ST_UPDISSUE   = 4'd3,
        ST_UPDWAIT    = 4'd4,
        ST_TXLINK     = 4'd5,
        ST_WAITACK    = 4'd6,
        ST_MCREAD     = 4'd7,
        ST_TXRSP      = 4'd8,
        ST_WAITWRDATA = 4'd9,
        ST_SLEEP      = 4'd10
    } entry_state_t;

    // Event kinds
    localparam logic [3:0] EV_ADMIT       = 4'd0;
    localparam logic [3:0] EV_LOOKUPDONE  = 4'd1;
    localparam logic [3:0] EV_UPDACCEPTED = 4'd2;
    localparam logic [3:0] EV_UPDDONE     = 4'd3;
    localparam logic [3:0] EV_SNOOPDONE   = 4'd4;
    localparam logic [3:0] EV_TXLINKDONE  = 4'd5;
    localparam logic [3:0] EV_MCDATA      = 4'd7;
    localparam logic [3:0] EV_COMPACK     = 4'd8;
    localparam logic [3:0] EV_WRDATA      = 4'd9;

    // Transaction kinds tested by value
    localparam logic [3:0] TK_UNKNOWN = 4'd0;
    localparam logic [3:0] TK_RDNOSNP = 4'd4;
    localparam logic [3:0] TK_EVICT   = 4'd12;

    // Action codes, 0 is none
    localparam logic [4:0] ACT_NONE       = 5'd0;
    localparam logic [4:0] ACT_DO_LOOKUP  = 5'd1;
    localparam logic [4:0] ACT_Q_SNOOPS   = 5'd2;
    localparam logic [4:0] ACT_COMMIT_MNT = 5'd4;
    localparam logic [4:0] ACT_REM_SHARER = 5'd5;
    localparam logic [4:0] ACT_UPD_SLC    = 5'd6;
    localparam logic [4:0] ACT_Q_TXREQ    = 5'd7;
    localparam logic [4:0] ACT_Q_COMPDATA = 5'd8;
    localparam logic [4:0] ACT_Q_COMP     = 5'd9;
    localparam logic [4:0] ACT_Q_DBID     = 5'd10;
    localparam logic [4:0] ACT_WAIT_ACK   = 5'd11;
    localparam logic [4:0] ACT_WAIT_WRDAT = 5'd12;
    localparam logic [4:0] ACT_STORE_WR   = 5'd13;
    localparam logic [4:0] ACT_RETIRE     = 5'd17;
    localparam logic [4:0] ACT_SLEEP      = 5'd18;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    // One event word, fields from the highest bit down
    typedef struct packed {
        logic       needs_comp_ack;
        logic       data_available;
        logic       slc_hit;
        logic       needs_snoop;
        logic       replay;
        logic [3:0] txn_kind;
        logic [3:0] action;
    } evt_word_t;

    // One result word, fields from the highest bit down
    typedef struct packed {
        logic [4:0]   second_effect;
        logic [4:0]   first_effect;
        entry_state_t new_state;
        logic         stepped;
    } step_res_t;

    function automatic logic kind_read(input logic [3:0] tk);
        return (tk inside {[4'd0:4'd3]});
    endfunction

    function automatic logic kind_maint(input logic [3:0] tk);
        return (tk inside {[4'd5:4'd7]});
    endfunction

    function automatic logic kind_write(input logic [3:0] tk);
        return (tk inside {[4'd8:4'd11]});
    endfunction

endpackage

[hw/rtl/coherence_txn_entry_fsm_core.sv]
// Top level of the coherence home-node queue entry state machine.
//
//   channel | dir | payload                                         | accepted when
//   s_*     | in  | event word: action, txn_kind, five flags        | s_tvalid & s_tready
//   m_*     | out | result word: stepped, new_state, two effects    | m_tvalid & m_tready
//
// One event word per cycle sustained while m_tready is high; each accepted word
// passes through the input register, then is decoded into the result register.
// The entry state register is updated in the same cycle the decoded word moves
// into the result register, so the next queued word always sees the new state.
// rst_n (async, active low) puts the entry in idle and empties both stages.
// A stalled output only backs up the input stage once both registers are full.
`include "coherence_txn_entry_fsm_core_defines.svh"

module coherence_txn_entry_fsm_core
    import coh_txn_pkg::*;
#(
    parameter int unsigned IN_W  = IN_TDATA_W,
    parameter int unsigned OUT_W = OUT_TDATA_W
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             s_tvalid,
    output logic             s_tready,
    // [3:0] action, [7:4] txn_kind, [8] replay, [9] needs_snoop,
    // [10] slc_hit, [11] data_available, [12] needs_comp_ack, rest zero
    input  logic [IN_W-1:0]  s_tdata,

    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] stepped, [4:1] new_state, [9:5] first_effect,
    // [14:10] second_effect, [15] zero
    output logic [OUT_W-1:0] m_tdata
);

    localparam int unsigned EVT_W = $bits(evt_word_t);
    localparam int unsigned RES_W = $bits(step_res_t);

    // Input stage
    logic         in_valid_reg;
    logic         in_valid_next;
    evt_word_t    in_word_reg;

    // Result stage
    logic         out_valid_reg;
    logic         out_valid_next;
    step_res_t    out_word_reg;

    entry_state_t state_reg;
    entry_state_t state_next;

    step_res_t    step_res;
    logic         s_fire;
    logic         advance;

    coh_txn_step u_step
    (
        .cur_state (state_reg),
        .evt       (in_word_reg),
        .res       (step_res)
    );

    // Word leaves the input stage when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : ((m_tready) ? 1'b0 : out_valid_reg);
        state_next     = advance ? step_res.new_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_IDLE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_word_reg <= evt_word_t'(s_tdata[EVT_W-1:0]);
        end
        if (advance)
        begin
            out_word_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-RES_W){1'b0}}, out_word_reg};

    // Checks
    `COH_ASSERT_NXT(a_state_follows_step, advance, state_reg == $past(step_res.new_state))
    `COH_ASSERT_NXT(a_state_holds_idle, !advance, $stable(state_reg))
    `COH_ASSERT_IMP(a_no_step_no_effect, out_valid_reg && !out_word_reg.stepped,
        (out_word_reg.first_effect == ACT_NONE) && (out_word_reg.second_effect == ACT_NONE))
    `COH_ASSERT_IMP(a_result_matches_state, out_valid_reg && !advance,
        out_word_reg.new_state == state_reg)

endmodule

[hw/rtl/coh_txn_step.sv]
// Next-state and action decode for one event against the current entry state.
module coh_txn_step
    import coh_txn_pkg::*;
(
    input  entry_state_t cur_state,
    input  evt_word_t    evt,
    output step_res_t    res
);

    always_comb
    begin
        res.stepped       = 1'b1;
        res.new_state     = cur_state;
        res.first_effect  = ACT_NONE;
        res.second_effect = ACT_NONE;

        case (cur_state)
            ST_IDLE:
            begin
                if (evt.action != EV_ADMIT)
                begin
                    res.stepped = 1'b0;
                end
                else if (evt.txn_kind == TK_RDNOSNP)
                begin
                    res.new_state    = ST_MCREAD;
                    res.first_effect = ACT_Q_TXREQ;
                end
                else if (kind_read(evt.txn_kind) || kind_maint(evt.txn_kind))
                begin
                    res.new_state    = ST_LOOKUP;
                    res.first_effect = ACT_DO_LOOKUP;
                end
                else if (evt.txn_kind == TK_EVICT)
                begin
                    res.new_state     = ST_IDLE;
                    res.first_effect  = ACT_REM_SHARER;
                    res.second_effect = ACT_Q_COMP;
                end
                else if (kind_write(evt.txn_kind))
                begin
                    res.new_state     = ST_WAITWRDATA;
                    res.first_effect  = ACT_Q_DBID;
                    res.second_effect = ACT_WAIT_WRDAT;
                end
                else
                begin
                    res.stepped = 1'b0;
                end
            end
            ST_LOOKUP:
            begin
                if (evt.action != EV_LOOKUPDONE)
                begin
                    res.stepped = 1'b0;
                end
                else if (evt.replay)
                begin
                    res.new_state    = ST_SLEEP;
                    res.first_effect = ACT_SLEEP;
                end
                else if (evt.needs_snoop)
                begin
                    res.new_state    = ST_WAITSNOOP;
                    res.first_effect = ACT_Q_SNOOPS;
                end
                else if (kind_read(evt.txn_kind))
                begin
                    res.new_state    = evt.slc_hit ? ST_UPDISSUE : ST_MCREAD;
                    res.first_effect = evt.slc_hit ? ACT_UPD_SLC : ACT_Q_TXREQ;
                end
                else if (kind_maint(evt.txn_kind))
                begin
                    res.new_state     = ST_IDLE;
                    res.first_effect  = ACT_COMMIT_MNT;
                    res.second_effect = ACT_Q_COMP;
                end
                else
                begin
                    res.stepped = 1'b0;
                end
            end
            ST_WAITSNOOP:
            begin
                if (evt.action != EV_SNOOPDONE)
                begin
                    res.stepped = 1'b0;
                end
                else if (kind_read(evt.txn_kind))
                begin
                    res.new_state    = evt.data_available ? ST_UPDISSUE : ST_MCREAD;
                    res.first_effect = evt.data_available ? ACT_UPD_SLC : ACT_Q_TXREQ;
                end
                else if (kind_maint(evt.txn_kind))
                begin
                    res.new_state     = ST_IDLE;
                    res.first_effect  = ACT_COMMIT_MNT;
                    res.second_effect = ACT_Q_COMP;
                end
                else
                begin
                    res.stepped = 1'b0;
                end
            end
            ST_MCREAD:
            begin
                if (evt.action != EV_MCDATA)
                begin
                    res.stepped = 1'b0;
                end
                else if (evt.txn_kind == TK_RDNOSNP)
                begin
                    res.new_state    = ST_TXLINK;
                    res.first_effect = ACT_Q_COMPDATA;
                end
                else
                begin
                    res.new_state    = ST_UPDISSUE;
                    res.first_effect = ACT_UPD_SLC;
                end
            end
            ST_UPDISSUE:
            begin
                // Edge with no actions
                if (evt.action == EV_UPDACCEPTED)
                begin
                    res.new_state = ST_UPDWAIT;
                end
                else
                begin
                    res.stepped = 1'b0;
                end
            end
            ST_UPDWAIT:
            begin
                if (evt.action != EV_UPDDONE)
                begin
                    res.stepped = 1'b0;
                end
                else if (evt.replay)
                begin
                    res.new_state    = ST_SLEEP;
                    res.first_effect = ACT_SLEEP;
                end
                else
                begin
                    res.new_state    = ST_TXLINK;
                    res.first_effect = ACT_Q_COMPDATA;
                end
            end
            ST_TXLINK:
            begin
                if (evt.action != EV_TXLINKDONE)
                begin
                    res.stepped = 1'b0;
                end
                else if (evt.needs_comp_ack || (evt.txn_kind == TK_UNKNOWN))
                begin
                    res.new_state    = ST_WAITACK;
                    res.first_effect = ACT_WAIT_ACK;
                end
                else
                begin
                    res.new_state    = ST_IDLE;
                    res.first_effect = ACT_RETIRE;
                end
            end
            ST_WAITWRDATA:
            begin
                if (evt.action == EV_WRDATA)
                begin
                    res.new_state     = ST_IDLE;
                    res.first_effect  = ACT_STORE_WR;
                    res.second_effect = ACT_RETIRE;
                end
                else
                begin
                    res.stepped = 1'b0;
                end
            end
            ST_WAITACK:
            begin
                if (evt.action == EV_COMPACK)
                begin
                    res.new_state    = ST_IDLE;
                    res.first_effect = ACT_RETIRE;
                end
                else
                begin
                    res.stepped = 1'b0;
                end
            end
            default:
            begin
                // txrsp and sleep have no way out but reset
                res.stepped = 1'b0;
            end
        endcase
    end

endmodule

[tb/sv/tb_coherence_txn_entry_fsm_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for the coherence entry FSM: directed table plus state-aware random words.

module tb_coherence_txn_entry_fsm_core;
    import coh_txn_pkg::*;

    // Run shape
    localparam int unsigned RAND_WORDS   = 530;
    localparam int unsigned TAIL_WORDS   = 6;     // sent after the entry is parked in sleep
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned IDLE_PCT     = 11;
    localparam int unsigned WELLFORM_PCT = 75;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned HOLD_AT      = 120;   // words sent before the long sink stall
    localparam int unsigned DRAIN_CYCLES = 8;     // two-stage pipe, plus margin

    // Quiet windows (in words sent) where one side never idles
    localparam int unsigned SRC_CALM_LO = 250;
    localparam int unsigned SRC_CALM_HI = 380;
    localparam int unsigned SNK_CALM_LO = 300;
    localparam int unsigned SNK_CALM_HI = 460;

    // Transaction kind class bounds and stimulus corner values
    localparam logic [3:0] TK_RD_LAST   = 4'd3;
    localparam logic [3:0] TK_RDUNIQUE  = 4'd2;
    localparam logic [3:0] TK_MNT_FIRST = 4'd5;
    localparam logic [3:0] TK_MNT_LAST  = 4'd7;
    localparam logic [3:0] TK_WR_FIRST  = 4'd8;
    localparam logic [3:0] TK_WR_LAST   = 4'd11;
    localparam logic [3:0] TK_NO_CLASS  = 4'd13;
    localparam logic [3:0] TK_ALL_ONES  = 4'd15;
    localparam logic [3:0] EV_ALL_ONES  = 4'd15;

    typedef enum logic [2:0] {
        CL_READ,
        CL_MAINT,
        CL_WRITE,
        CL_NOSNP,
        CL_EVICT,
        CL_NONE
    } txn_class_t;

    // One stimulus word; golden is used only when typed is set
    typedef struct {
        evt_word_t word;
        bit        typed;
        step_res_t golden;
    } stim_row_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    entry_state_t model_state = ST_IDLE;   // predicted entry state
    step_res_t    expected_q[$];           // predicted result words, oldest first
    stim_row_t    plan[$];                 // directed table
    int unsigned  words_sent = 0;
    int unsigned  errors     = 0;
    int unsigned  cycles     = 0;
    logic         hold_off   = 1'b0;

    coherence_txn_entry_fsm_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("coherence_txn_entry_fsm_core: mismatch");
            $finish;
        end
    end

    function automatic evt_word_t evt(input logic [3:0] ev, input logic [3:0] tk,
                                      input logic rp, input logic sn, input logic hit,
                                      input logic dat, input logic ack);
        evt_word_t w;
        w.action         = ev;
        w.txn_kind       = tk;
        w.replay         = rp;
        w.needs_snoop    = sn;
        w.slc_hit        = hit;
        w.data_available = dat;
        w.needs_comp_ack = ack;
        return w;
    endfunction

    function automatic step_res_t res_of(input logic stepped, input entry_state_t st,
                                         input logic [4:0] e1, input logic [4:0] e2);
        step_res_t r;
        r.stepped       = stepped;
        r.new_state     = st;
        r.first_effect  = e1;
        r.second_effect = e2;
        return r;
    endfunction

    // Kind 0 (unknown) counts as a read; 13..15 fall in no class
    function automatic txn_class_t classify(input logic [3:0] tk);
        if (tk == TK_RDNOSNP)
            return CL_NOSNP;
        if (tk <= TK_RD_LAST)
            return CL_READ;
        if (tk >= TK_MNT_FIRST && tk <= TK_MNT_LAST)
            return CL_MAINT;
        if (tk >= TK_WR_FIRST && tk <= TK_WR_LAST)
            return CL_WRITE;
        if (tk == TK_EVICT)
            return CL_EVICT;
        return CL_NONE;
    endfunction

    // Next-state and action decode; first matching edge wins, no match keeps the state
    function automatic step_res_t next_entry(input entry_state_t cur, input evt_word_t w);
        step_res_t  r;
        txn_class_t cls;
        cls = classify(w.txn_kind);
        r   = res_of(1'b0, cur, ACT_NONE, ACT_NONE);
        case (cur)
            ST_IDLE:
                if (w.action == EV_ADMIT)
                begin
                    if (cls == CL_NOSNP)
                        r = res_of(1'b1, ST_MCREAD, ACT_Q_TXREQ, ACT_NONE);
                    else if (cls == CL_READ || cls == CL_MAINT)
                        r = res_of(1'b1, ST_LOOKUP, ACT_DO_LOOKUP, ACT_NONE);
                    else if (cls == CL_EVICT)
                        r = res_of(1'b1, ST_IDLE, ACT_REM_SHARER, ACT_Q_COMP);
                    else if (cls == CL_WRITE)
                        r = res_of(1'b1, ST_WAITWRDATA, ACT_Q_DBID, ACT_WAIT_WRDAT);
                end
            ST_LOOKUP:
                if (w.action == EV_LOOKUPDONE)
                begin
                    if (w.replay)
                        r = res_of(1'b1, ST_SLEEP, ACT_SLEEP, ACT_NONE);
                    else if (w.needs_snoop)
                        r = res_of(1'b1, ST_WAITSNOOP, ACT_Q_SNOOPS, ACT_NONE);
                    else if (cls == CL_READ && w.slc_hit)
                        r = res_of(1'b1, ST_UPDISSUE, ACT_UPD_SLC, ACT_NONE);
                    else if (cls == CL_READ)
                        r = res_of(1'b1, ST_MCREAD, ACT_Q_TXREQ, ACT_NONE);
                    else if (cls == CL_MAINT)
                        r = res_of(1'b1, ST_IDLE, ACT_COMMIT_MNT, ACT_Q_COMP);
                end
            ST_WAITSNOOP:
                if (w.action == EV_SNOOPDONE)
                begin
                    if (cls == CL_READ && w.data_available)
                        r = res_of(1'b1, ST_UPDISSUE, ACT_UPD_SLC, ACT_NONE);
                    else if (cls == CL_READ)
                        r = res_of(1'b1, ST_MCREAD, ACT_Q_TXREQ, ACT_NONE);
                    else if (cls == CL_MAINT)
                        r = res_of(1'b1, ST_IDLE, ACT_COMMIT_MNT, ACT_Q_COMP);
                end
            ST_MCREAD:
                if (w.action == EV_MCDATA)
                begin
                    if (w.txn_kind == TK_RDNOSNP)
                        r = res_of(1'b1, ST_TXLINK, ACT_Q_COMPDATA, ACT_NONE);
                    else
                        r = res_of(1'b1, ST_UPDISSUE, ACT_UPD_SLC, ACT_NONE);
                end
            ST_UPDISSUE:
                if (w.action == EV_UPDACCEPTED)
                    r = res_of(1'b1, ST_UPDWAIT, ACT_NONE, ACT_NONE);
            ST_UPDWAIT:
                if (w.action == EV_UPDDONE)
                begin
                    if (w.replay)
                        r = res_of(1'b1, ST_SLEEP, ACT_SLEEP, ACT_NONE);
                    else
                        r = res_of(1'b1, ST_TXLINK, ACT_Q_COMPDATA, ACT_NONE);
                end
            ST_TXLINK:
                if (w.action == EV_TXLINKDONE)
                begin
                    if (w.needs_comp_ack || w.txn_kind == TK_UNKNOWN)
                        r = res_of(1'b1, ST_WAITACK, ACT_WAIT_ACK, ACT_NONE);
                    else
                        r = res_of(1'b1, ST_IDLE, ACT_RETIRE, ACT_NONE);
                end
            ST_WAITWRDATA:
                if (w.action == EV_WRDATA)
                    r = res_of(1'b1, ST_IDLE, ACT_STORE_WR, ACT_RETIRE);
            ST_WAITACK:
                if (w.action == EV_COMPACK)
                    r = res_of(1'b1, ST_IDLE, ACT_RETIRE, ACT_NONE);
            default:
                ;   // sleep and txrsp: only reset gets out
        endcase
        return r;
    endfunction

    // Random word. Most of the time it is the event the current state waits for, with
    // random kind and flags, so the walk gets through the whole graph; the rest is noise.
    // Replay on a lookup or update completion parks the entry in sleep for good, so it
    // is only let through once the run is meant to end there.
    function automatic evt_word_t pick_evt(input entry_state_t cur, input bit to_sleep);
        evt_word_t w;
        w = evt_word_t'(13'($urandom));
        if (to_sleep || $urandom_range(99) < WELLFORM_PCT)
        begin
            if ($urandom_range(99) < 90)
                w.txn_kind = 4'($urandom_range(TK_EVICT));
            else
                w.txn_kind = 4'($urandom_range(TK_ALL_ONES, TK_NO_CLASS));
            case (cur)
                ST_IDLE:       w.action = EV_ADMIT;
                ST_LOOKUP:     w.action = EV_LOOKUPDONE;
                ST_WAITSNOOP:  w.action = EV_SNOOPDONE;
                ST_MCREAD:     w.action = EV_MCDATA;
                ST_UPDISSUE:   w.action = EV_UPDACCEPTED;
                ST_UPDWAIT:    w.action = EV_UPDDONE;
                ST_TXLINK:     w.action = EV_TXLINKDONE;
                ST_WAITWRDATA: w.action = EV_WRDATA;
                ST_WAITACK:    w.action = EV_COMPACK;
                default:       ;
            endcase
        end
        if ((cur == ST_LOOKUP && w.action == EV_LOOKUPDONE) ||
            (cur == ST_UPDWAIT && w.action == EV_UPDDONE))
            w.replay = to_sleep & 1'($urandom_range(1));
        return w;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input stim_row_t row);
        plan.insert(plan.size(), row);
    endtask

    // Offer one word, maybe after a one-cycle gap, and score it at the accepting edge.
    // Called at a rising edge; s_tvalid gets exactly one assignment in that step.
    task automatic send_evt(input stim_row_t row);
        int unsigned gap;
        step_res_t   pred;
        gap = 0;
        if (!(words_sent >= SRC_CALM_LO && words_sent < SRC_CALM_HI) &&
            $urandom_range(99) < IDLE_PCT)
            gap = 1;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(row.word);
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        pred        = next_entry(model_state, row.word);
        model_state = pred.new_state;
        expected_q.insert(expected_q.size(), row.typed ? row.golden : pred);
        words_sent++;
    endtask

    task automatic field_chk(input string name, input logic [4:0] want, input logic [4:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Sink: score each result word against the oldest prediction, then pick tready
    always @(posedge clk)
    begin : sink
        step_res_t got;
        step_res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = step_res_t'(m_tdata[$bits(step_res_t)-1:0]);
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result word %h with none expected", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    field_chk("stepped", 5'(want.stepped), 5'(got.stepped));
                    field_chk("new_state", 5'(want.new_state), 5'(got.new_state));
                    field_chk("first_effect", want.first_effect, got.first_effect);
                    field_chk("second_effect", want.second_effect, got.second_effect);
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (words_sent >= SNK_CALM_LO && words_sent < SNK_CALM_HI)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Long sink stall: both pipe stages fill and s_tready drops while words keep coming
    initial
    begin : backpressure
        while (words_sent < HOLD_AT)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : stimulus
        int unsigned i;

        // Directed table. Rows with a typed golden are no-match cases and edges whose
        // outcome is plain from the graph; the rest are scored by next_entry.
        // out-of-range event kind, every bit set
        add_row('{evt(EV_ALL_ONES, TK_ALL_ONES, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 1'b1,
                  res_of(1'b0, ST_IDLE, ACT_NONE, ACT_NONE)});
        // admit of a kind in no class
        add_row('{evt(EV_ADMIT, TK_NO_CLASS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                  res_of(1'b0, ST_IDLE, ACT_NONE, ACT_NONE)});
        // evict retires on admit
        add_row('{evt(EV_ADMIT, TK_EVICT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                  res_of(1'b1, ST_IDLE, ACT_REM_SHARER, ACT_Q_COMP)});
        // write path
        add_row('{evt(EV_ADMIT, TK_WR_FIRST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                  res_of(1'b1, ST_WAITWRDATA, ACT_Q_DBID, ACT_WAIT_WRDAT)});
        add_row('{evt(EV_COMPACK, TK_WR_FIRST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                  res_of(1'b0, ST_WAITWRDATA, ACT_NONE, ACT_NONE)});
        add_row('{evt(EV_WRDATA, TK_WR_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                  res_of(1'b1, ST_IDLE, ACT_STORE_WR, ACT_RETIRE)});
        // no-snoop read straight to memory
        add_row('{evt(EV_ADMIT, TK_RDNOSNP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_MCDATA, TK_RDNOSNP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_TXLINKDONE, TK_RDNOSNP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        // unknown kind, all-zero word: cache hit path, then comp-ack wait
        add_row('{evt(EV_ADMIT, TK_UNKNOWN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_LOOKUPDONE, TK_UNKNOWN, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b0, '0});
        // update accepted moves without any action
        add_row('{evt(EV_UPDACCEPTED, TK_UNKNOWN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                  res_of(1'b1, ST_UPDWAIT, ACT_NONE, ACT_NONE)});
        add_row('{evt(EV_UPDDONE, TK_UNKNOWN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_TXLINKDONE, TK_UNKNOWN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_COMPACK, TK_UNKNOWN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        // maintenance with snoops
        add_row('{evt(EV_ADMIT, TK_MNT_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_LOOKUPDONE, TK_MNT_LAST, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_SNOOPDONE, TK_MNT_LAST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        // read unique: classless and evict kinds stall the lookup, then snoop miss
        add_row('{evt(EV_ADMIT, TK_RDUNIQUE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_LOOKUPDONE, TK_NO_CLASS, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1,
                  res_of(1'b0, ST_LOOKUP, ACT_NONE, ACT_NONE)});
        add_row('{evt(EV_LOOKUPDONE, TK_EVICT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                  res_of(1'b0, ST_LOOKUP, ACT_NONE, ACT_NONE)});
        add_row('{evt(EV_LOOKUPDONE, TK_RDUNIQUE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_SNOOPDONE, TK_RDUNIQUE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        add_row('{evt(EV_MCDATA, TK_RDUNIQUE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0, '0});
        // wrong event while waiting to issue the update
        add_row('{evt(EV_UPDDONE, TK_RDUNIQUE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 1'b1,
                  res_of(1'b0, ST_UPDISSUE, ACT_NONE, ACT_NONE)});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            send_evt(plan[k]);

        for (i = 0; i < RAND_WORDS; i++)
            send_evt('{pick_evt(model_state, 1'b0), 1'b0, '0});

        // Wind down into sleep, then show the entry stays parked
        while (model_state != ST_SLEEP)
            send_evt('{pick_evt(model_state, 1'b1), 1'b0, '0});
        for (i = 0; i < TAIL_WORDS; i++)
            send_evt('{pick_evt(model_state, 1'b0), 1'b0, '0});
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("coherence_txn_entry_fsm_core: match");
        else
            $display("coherence_txn_entry_fsm_core: mismatch");
        $finish;
    end

endmodule
